@@ hdl/btu_pkg.sv @@
// Shared constants, payload types and pipeline records for the Bhaskara trig unit.
package btu_pkg;

  localparam int DATA_WIDTH = 32;
  localparam int FRAC_BITS  = 16;

  localparam logic [1:0] OP_SIN = 2'd0;
  localparam logic [1:0] OP_COS = 2'd1;
  localparam logic [1:0] OP_TAN = 2'd2;

  // pi at 60 fraction bits, rounded to nearest at FRAC_BITS
  localparam logic [63:0] PI_Q60      = 64'h3243F6A8885A308D;
  localparam int          RND_SH      = 60 - FRAC_BITS;
  localparam logic [63:0] RND_HALF    = 64'd1 << (RND_SH - 1);
  localparam logic [63:0] PI_FX       = (PI_Q60 + RND_HALF) >> RND_SH;
  localparam logic [63:0] PI_Q30      = PI_Q60 >> 30;
  localparam logic [63:0] PI_SQ_FX    = (PI_Q30 * PI_Q30 + RND_HALF) >> RND_SH;
  localparam logic [63:0] TWO_PI_FX   = 64'd2 * PI_FX;
  localparam logic [63:0] SIN_DEN_FX  = 64'd5 * PI_SQ_FX;

  // reduction by two pi: reciprocal multiply, exact for all 31-bit magnitudes
  localparam int          RED_SH      = 50;
  localparam logic [63:0] RED_MUL_FX  = ((64'd1 << RED_SH) + TWO_PI_FX - 64'd1) / TWO_PI_FX;
  localparam int          Q_W         = 14;

  localparam int X_W    = 18;
  localparam int PISQ_W = 20;
  localparam int SC_W   = 22;
  localparam int M_W    = FRAC_BITS + 1;
  localparam int TN_W   = M_W + FRAC_BITS;
  localparam int TQ_W   = TN_W + 1;

  localparam logic [X_W-1:0]    PI_K      = PI_FX[X_W-1:0];
  localparam logic [X_W:0]      TWO_PI_K  = {PI_K, 1'b0};
  localparam logic [PISQ_W-1:0] PI_SQ_K   = PI_SQ_FX[PISQ_W-1:0];
  localparam logic [SC_W-1:0]   SIN_DEN_K = SIN_DEN_FX[SC_W-1:0];
  localparam logic [31:0]       RED_MUL   = RED_MUL_FX[31:0];

  localparam int SC_STEPS  = 4;
  localparam int SC_STAGES = FRAC_BITS / SC_STEPS;
  localparam int TN_STEPS  = 3;
  localparam int TN_STAGES = TN_W / TN_STEPS;

  localparam logic [M_W-1:0]  M_ONE    = M_W'(1) << FRAC_BITS;
  localparam logic [TQ_W-1:0] MAX_POS  = (TQ_W'(1) << (DATA_WIDTH - 1)) - TQ_W'(1);
  localparam logic [TQ_W-1:0] MAX_NEGM = TQ_W'(1) << (DATA_WIDTH - 1);

  typedef struct packed {
    logic [1:0]                   opcode;
    logic signed [DATA_WIDTH-1:0] angle;
  } req_t;

  typedef struct packed {
    logic signed [DATA_WIDTH-1:0] value;
    logic                         saturated;
  } res_t;

  typedef struct packed {
    logic [1:0]           op;
    logic                 s_neg;
    logic                 c_neg;
    logic                 s_int;
    logic                 c_int;
    logic [SC_W-1:0]      s_den;
    logic [SC_W-1:0]      c_den;
    logic [SC_W-1:0]      s_rem;
    logic [SC_W-1:0]      c_rem;
    logic [FRAC_BITS-1:0] s_frac;
    logic [FRAC_BITS-1:0] c_frac;
  } sc_div_t;

  typedef struct packed {
    logic [1:0]            op;
    logic [DATA_WIDTH-1:0] res_sc;
    logic                  t_neg;
    logic                  c_zero;
    logic [M_W-1:0]        den;
    logic [M_W-1:0]        rem;
    logic [TN_W-1:0]       num;
  } tan_div_t;

endpackage

@@ hdl/btu_div_steps.sv @@
// A few restoring long-division steps; quotient bits shift into the numerator word.
module btu_div_steps #(
  parameter int NUM_W = 16,
  parameter int DEN_W = 22,
  parameter int STEPS = 4
) (
  input  logic [DEN_W-1:0] den,
  input  logic [DEN_W-1:0] rem_in,
  input  logic [NUM_W-1:0] num_in,
  output logic [DEN_W-1:0] rem_out,
  output logic [NUM_W-1:0] num_out
);

  logic [DEN_W:0]   t;
  logic [DEN_W-1:0] r;
  logic [NUM_W-1:0] n;

  always_comb begin
    r = rem_in;
    n = num_in;
    t = '0;
    for (int i = 0; i < STEPS; i++) begin
      t = {r, n[NUM_W-1]};
      if (t >= {1'b0, den}) begin
        t = t - {1'b0, den};
        n = {n[NUM_W-2:0], 1'b1};
      end else begin
        n = {n[NUM_W-2:0], 1'b0};
      end
      r = t[DEN_W-1:0];
    end
    rem_out = r;
    num_out = n;
  end

endmodule

@@ hdl/bhaskara_trig_unit.sv @@
// Pipeline: 25 register stages between an accepted request and its result.
// Throughput: one request per cycle while res_ready is high; every stage has its own valid
// bit and a stage loads whenever it is empty or the stage after it moves, so bubbles close up.
// Depth is set by 16 sine/cosine quotient steps (4 stages) and 33 tangent steps (11 stages).
// Reset: synchronous, clears all valid bits; no other state.
module bhaskara_trig_unit
  import btu_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic req_valid,
  output logic req_ready,
  input  req_t req_data,
  output logic res_valid,
  input  logic res_ready,
  output res_t res_data
);

  localparam int SC_FIRST = 7;
  localparam int SC_END   = SC_FIRST + SC_STAGES;
  localparam int TN_INIT  = SC_END + 1;
  localparam int NS       = TN_INIT + TN_STAGES + 2;

  logic [NS-1:0] v;
  logic [NS-1:0] ld;
  logic [NS-1:0] v_in;

  always_comb begin
    ld[NS-1] = !v[NS-1] || res_ready;
    for (int i = NS - 2; i >= 0; i--) begin
      ld[i] = !v[i] || ld[i+1];
    end
  end

  assign v_in      = {v[NS-2:0], req_valid};
  assign req_ready = ld[0];
  assign res_valid = v[NS-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      for (int i = 0; i < NS; i++) begin
        if (ld[i]) begin
          v[i] <= v_in[i];
        end
      end
    end
  end

  // stage 0: magnitude of the angle
  logic [1:0]  op0;
  logic        neg0;
  logic [31:0] abs0;

  always_ff @(posedge clk) begin
    if (ld[0]) begin
      op0  <= req_data.opcode;
      neg0 <= req_data.angle[DATA_WIDTH-1];
      abs0 <= req_data.angle[DATA_WIDTH-1] ? 32'(-req_data.angle) : 32'(req_data.angle);
    end
  end

  // stage 1: quotient by two pi
  logic [63:0]    prod1;
  logic [1:0]     op1;
  logic           neg1;
  logic [31:0]    abs1;
  logic [Q_W-1:0] q1;

  assign prod1 = {32'b0, abs0} * {32'b0, RED_MUL};

  always_ff @(posedge clk) begin
    if (ld[1]) begin
      op1  <= op0;
      neg1 <= neg0;
      abs1 <= abs0;
      q1   <= prod1[RED_SH +: Q_W];
    end
  end

  // stage 2: quotient times two pi
  logic [Q_W+X_W:0] qd_full;
  logic [1:0]       op2;
  logic             neg2;
  logic [31:0]      abs2;
  logic [31:0]      qd2;

  assign qd_full = {{(X_W+1){1'b0}}, q1} * {{Q_W{1'b0}}, TWO_PI_K};

  always_ff @(posedge clk) begin
    if (ld[2]) begin
      op2  <= op1;
      neg2 <= neg1;
      abs2 <= abs1;
      qd2  <= qd_full[31:0];
    end
  end

  // stage 3: signed remainder
  logic [31:0]        rm_full;
  logic signed [19:0] rm_s;
  logic [1:0]         op3;
  logic signed [19:0] r3;

  assign rm_full = abs2 - qd2;
  assign rm_s    = signed'({1'b0, rm_full[X_W:0]});

  always_ff @(posedge clk) begin
    if (ld[3]) begin
      op3 <= op2;
      r3  <= neg2 ? -rm_s : rm_s;
    end
  end

  // stage 4: quadrant folding
  localparam logic signed [20:0] PI_S  = signed'({3'b0, PI_K});
  localparam logic signed [20:0] TWO_S = signed'({2'b0, TWO_PI_K});

  logic signed [20:0] rr;
  logic signed [20:0] rc;
  logic signed [20:0] ac;
  logic signed [20:0] xc_s;
  logic               sn_c;
  logic               cn_c;
  logic [1:0]         op4;
  logic [X_W-1:0]     xs4;
  logic [X_W-1:0]     xc4;
  logic               sn4;
  logic               cn4;

  always_comb begin
    rr   = {r3[19], r3};
    sn_c = 1'b0;
    if (rr < 0) begin
      rr = rr + TWO_S;
    end
    if (rr > PI_S) begin
      rr   = rr - PI_S;
      sn_c = 1'b1;
    end
    rc = {r3[19], r3};
    if (rc > PI_S) begin
      rc = rc - TWO_S;
    end
    if (rc < -PI_S) begin
      rc = rc + TWO_S;
    end
    ac   = (rc < 0) ? -rc : rc;
    cn_c = (ac <<< 1) > PI_S;
    xc_s = cn_c ? (PI_S - ac) : ac;
  end

  always_ff @(posedge clk) begin
    if (ld[4]) begin
      op4 <= op3;
      xs4 <= rr[X_W-1:0];
      xc4 <= xc_s[X_W-1:0];
      sn4 <= sn_c;
      cn4 <= cn_c;
    end
  end

  // stage 5: x(pi - x) and x^2, rounded
  localparam logic [2*X_W-1:0] HALF_P = (2*X_W)'(1) << (FRAC_BITS - 1);

  logic [X_W-1:0]   pmx;
  logic [2*X_W-1:0] sp;
  logic [2*X_W-1:0] cp;
  logic [1:0]       op5;
  logic             sn5;
  logic             cn5;
  logic [X_W-1:0]   c5;
  logic [X_W-1:0]   xq5;

  assign pmx = PI_K - xs4;
  assign sp  = {{X_W{1'b0}}, xs4} * {{X_W{1'b0}}, pmx} + HALF_P;
  assign cp  = {{X_W{1'b0}}, xc4} * {{X_W{1'b0}}, xc4} + HALF_P;

  always_ff @(posedge clk) begin
    if (ld[5]) begin
      op5 <= op4;
      sn5 <= sn4;
      cn5 <= cn4;
      c5  <= sp[FRAC_BITS +: X_W];
      xq5 <= cp[FRAC_BITS +: X_W];
    end
  end

  // stage 6: numerators, denominators and integer quotient bit
  logic [SC_W-1:0] s_n;
  logic [SC_W-1:0] s_d;
  logic [SC_W-1:0] c_n;
  logic [SC_W-1:0] c_d;
  logic            s_i;
  logic            c_i;
  sc_div_t         sc_q [0:SC_STAGES];

  assign s_n = {c5, 4'b0};
  assign s_d = SIN_DEN_K - {2'b0, c5, 2'b0};
  assign c_n = {2'b0, PI_SQ_K} - {2'b0, xq5, 2'b0};
  assign c_d = {2'b0, PI_SQ_K} + {4'b0, xq5};
  assign s_i = s_n >= s_d;
  assign c_i = c_n >= c_d;

  always_ff @(posedge clk) begin
    if (ld[6]) begin
      sc_q[0].op     <= op5;
      sc_q[0].s_neg  <= sn5;
      sc_q[0].c_neg  <= cn5;
      sc_q[0].s_int  <= s_i;
      sc_q[0].c_int  <= c_i;
      sc_q[0].s_den  <= s_d;
      sc_q[0].c_den  <= c_d;
      sc_q[0].s_rem  <= s_i ? (s_n - s_d) : s_n;
      sc_q[0].c_rem  <= c_i ? (c_n - c_d) : c_n;
      sc_q[0].s_frac <= '0;
      sc_q[0].c_frac <= '0;
    end
  end

  // sine and cosine fraction bits
  for (genvar k = 1; k <= SC_STAGES; k++) begin : g_sc
    logic [SC_W-1:0]      s_rem_n;
    logic [SC_W-1:0]      c_rem_n;
    logic [FRAC_BITS-1:0] s_frac_n;
    logic [FRAC_BITS-1:0] c_frac_n;
    sc_div_t              sc_next;

    btu_div_steps #(.NUM_W(FRAC_BITS), .DEN_W(SC_W), .STEPS(SC_STEPS)) u_sdiv (
      .den     (sc_q[k-1].s_den),
      .rem_in  (sc_q[k-1].s_rem),
      .num_in  (sc_q[k-1].s_frac),
      .rem_out (s_rem_n),
      .num_out (s_frac_n)
    );

    btu_div_steps #(.NUM_W(FRAC_BITS), .DEN_W(SC_W), .STEPS(SC_STEPS)) u_cdiv (
      .den     (sc_q[k-1].c_den),
      .rem_in  (sc_q[k-1].c_rem),
      .num_in  (sc_q[k-1].c_frac),
      .rem_out (c_rem_n),
      .num_out (c_frac_n)
    );

    always_comb begin
      sc_next        = sc_q[k-1];
      sc_next.s_rem  = s_rem_n;
      sc_next.c_rem  = c_rem_n;
      sc_next.s_frac = s_frac_n;
      sc_next.c_frac = c_frac_n;
    end

    always_ff @(posedge clk) begin
      if (ld[SC_FIRST+k-1]) begin
        sc_q[k] <= sc_next;
      end
    end
  end

  // round sine and cosine magnitudes
  sc_div_t        scl;
  logic           s_up;
  logic           c_up;
  logic [1:0]     op11;
  logic           sn11;
  logic           cn11;
  logic [M_W-1:0] ms11;
  logic [M_W-1:0] mc11;

  assign scl  = sc_q[SC_STAGES];
  assign s_up = {scl.s_rem, 1'b0} >= {1'b0, scl.s_den};
  assign c_up = {scl.c_rem, 1'b0} >= {1'b0, scl.c_den};

  always_ff @(posedge clk) begin
    if (ld[SC_END]) begin
      op11 <= scl.op;
      sn11 <= scl.s_neg;
      cn11 <= scl.c_neg;
      ms11 <= {scl.s_int, scl.s_frac} + M_W'(s_up);
      mc11 <= {scl.c_int, scl.c_frac} + M_W'(c_up);
    end
  end

  // signed sine/cosine results and tangent setup
  logic [DATA_WIDTH-1:0] ms_w;
  logic [DATA_WIDTH-1:0] mc_w;
  logic [DATA_WIDTH-1:0] sv;
  logic [DATA_WIDTH-1:0] cv;
  logic [DATA_WIDTH-1:0] rsc;
  tan_div_t              tn [0:TN_STAGES];

  assign ms_w = {{(DATA_WIDTH-M_W){1'b0}}, ms11};
  assign mc_w = {{(DATA_WIDTH-M_W){1'b0}}, mc11};
  assign sv   = sn11 ? (~ms_w + 1'b1) : ms_w;
  assign cv   = cn11 ? (~mc_w + 1'b1) : mc_w;

  always_comb begin
    case (op11)
      OP_SIN:  rsc = sv;
      OP_COS:  rsc = cv;
      default: rsc = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (ld[TN_INIT]) begin
      tn[0].op     <= op11;
      tn[0].res_sc <= rsc;
      tn[0].t_neg  <= (sn11 && ms11 != '0) != (cn11 && mc11 != '0);
      tn[0].c_zero <= mc11 == '0;
      tn[0].den    <= mc11;
      tn[0].rem    <= '0;
      tn[0].num    <= {ms11, {FRAC_BITS{1'b0}}};
    end
  end

  // tangent quotient
  for (genvar k = 1; k <= TN_STAGES; k++) begin : g_tn
    logic [M_W-1:0]  rem_n;
    logic [TN_W-1:0] num_n;
    tan_div_t        tn_next;

    btu_div_steps #(.NUM_W(TN_W), .DEN_W(M_W), .STEPS(TN_STEPS)) u_tdiv (
      .den     (tn[k-1].den),
      .rem_in  (tn[k-1].rem),
      .num_in  (tn[k-1].num),
      .rem_out (rem_n),
      .num_out (num_n)
    );

    always_comb begin
      tn_next     = tn[k-1];
      tn_next.rem = rem_n;
      tn_next.num = num_n;
    end

    always_ff @(posedge clk) begin
      if (ld[TN_INIT+k]) begin
        tn[k] <= tn_next;
      end
    end
  end

  // round, clamp and select
  tan_div_t        tl;
  logic            t_up;
  logic [TQ_W-1:0] tq;
  res_t            res_c;
  logic [1:0]      op_o;

  assign tl   = tn[TN_STAGES];
  assign t_up = {tl.rem, 1'b0} >= {1'b0, tl.den};
  assign tq   = {1'b0, tl.num} + TQ_W'(t_up);

  always_comb begin
    res_c.value     = signed'(tl.res_sc);
    res_c.saturated = 1'b0;
    if (tl.op == OP_TAN) begin
      if (tl.c_zero) begin
        res_c.value = '0;
      end else if (tl.t_neg) begin
        if (tq > MAX_NEGM) begin
          res_c.value     = signed'(MAX_NEGM[DATA_WIDTH-1:0]);
          res_c.saturated = 1'b1;
        end else begin
          res_c.value = signed'(~tq[DATA_WIDTH-1:0] + 1'b1);
        end
      end else begin
        if (tq > MAX_POS) begin
          res_c.value     = signed'(MAX_POS[DATA_WIDTH-1:0]);
          res_c.saturated = 1'b1;
        end else begin
          res_c.value = signed'(tq[DATA_WIDTH-1:0]);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ld[NS-1]) begin
      res_data <= res_c;
      op_o     <= tl.op;
    end
  end

  a_sat_tan_only: assert property (@(posedge clk) disable iff (rst)
    (v[NS-1] && res_data.saturated) |-> op_o == OP_TAN)
    else $error("saturation flagged on a non-tangent result");

  a_unused_op_zero: assert property (@(posedge clk) disable iff (rst)
    (v[NS-1] && op_o != OP_SIN && op_o != OP_COS && op_o != OP_TAN)
      |-> (res_data.value == '0 && !res_data.saturated))
    else $error("unused opcode produced a nonzero result");

  a_unit_bound: assert property (@(posedge clk) disable iff (rst)
    v[SC_END] |-> (ms11 <= M_ONE && mc11 <= M_ONE))
    else $error("sine or cosine magnitude above one");

  a_enter: assert property (@(posedge clk) disable iff (rst)
    (req_valid && req_ready) |=> v[0])
    else $error("accepted request did not enter the pipeline");

endmodule
